[rtl/dmxpa_pkg.sv]
// Shared types, constants and helpers for the lighting universe pixel assembler.
`timescale 1ns / 1ps

package dmxpa_pkg;

  // Item kinds on the input stream
  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_PIXEL  = 2'd1;
  localparam logic [1:0] KIND_END    = 2'd2;
  localparam logic [1:0] KIND_TICK   = 2'd3;

  // Configuration register indexes
  localparam int unsigned CFG_INDEX_W = 4;
  localparam logic [CFG_INDEX_W-1:0] REG_START_UNIVERSE = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LED_COUNT      = 4'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_UNIVERSE_COUNT = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_IDLE_TIMEOUT   = 4'd3;
  localparam int unsigned CFG_DATA_W = 16;

  // Register reset values
  localparam logic [14:0] START_UNIVERSE_RST = 15'd0;
  localparam logic [13:0] LED_COUNT_RST      = 14'd3888;
  localparam logic [5:0]  UNIVERSE_COUNT_RST = 6'd23;
  localparam logic [15:0] IDLE_TIMEOUT_RST   = 16'd3000;

  // Frame limits
  localparam int unsigned MAX_UNIVERSES = 32;
  localparam int unsigned MAX_LEDS      = 8192;
  localparam int unsigned MAP_W         = 32;
  localparam int unsigned TRACK_LIMIT   = (MAX_UNIVERSES < MAP_W) ? MAX_UNIVERSES : MAP_W;

  // Packet length clamp and divide-by-three through a scaled reciprocal
  localparam logic [9:0] PACKET_LIMIT = 10'd512;
  localparam int unsigned RECIP3       = 683;
  localparam int unsigned RECIP3_SHIFT = 11;

  // Queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // Stream widths
  localparam int unsigned IN_DATA_W  = 56;
  localparam int unsigned OUT_DATA_W = 56;

  typedef struct packed {
    logic [14:0] start_universe;
    logic [13:0] led_count;
    logic [5:0]  universe_count;
    logic [15:0] idle_timeout_ms;
  } cfg_t;

  // Classified item handed from front to back
  typedef struct packed {
    logic [1:0]  kind;
    logic        uni_ok;
    logic        mark;
    logic [4:0]  rel_bit;
    logic [7:0]  pixels;
    logic [22:0] offset;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
  } cmd_t;

  typedef struct packed {
    logic        pixel_write;
    logic [12:0] pixel_address;
    logic [7:0]  out_red;
    logic [7:0]  out_green;
    logic [7:0]  out_blue;
    logic        frame_show;
    logic [15:0] frame_number;
    logic        activity_led;
  } res_t;

  // Universes tracked in the bitmap: universe_count capped at the map size
  function automatic logic [5:0] tracked_count(input logic [5:0] universe_count);
    logic [5:0] lim;
    lim = 6'(TRACK_LIMIT);
    tracked_count = (universe_count > lim) ? lim : universe_count;
  endfunction

endpackage

[rtl/dmxpa_front.sv]
// Front: accepts input items, clamps and divides the header length, computes universe offset.
`timescale 1ns / 1ps

module dmxpa_front (
  input  logic                 clk,
  input  logic                 rst,
  input  dmxpa_pkg::cfg_t      cfg,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_kind,
  input  logic [14:0]          in_universe,
  input  logic [9:0]           in_packet_length,
  input  logic [7:0]           in_red,
  input  logic [7:0]           in_green,
  input  logic [7:0]           in_blue,
  output logic                 cmd_valid,
  input  logic                 cmd_ready,
  output dmxpa_pkg::cmd_t      cmd
);

  logic            s1_valid;
  dmxpa_pkg::cmd_t s1;
  logic            s2_valid;
  dmxpa_pkg::cmd_t s2;
  logic            adv1;
  logic            adv2;

  logic [9:0]      len_c;
  logic [19:0]     len_prod;
  logic [15:0]     diff;
  logic            uni_ok;
  logic [5:0]      tracked;
  dmxpa_pkg::cmd_t s1_next;
  dmxpa_pkg::cmd_t s2_next;

  // Elastic two-stage pipe
  assign adv2     = !s2_valid || cmd_ready;
  assign adv1     = !s1_valid || adv2;
  assign in_ready = adv1;

  // Stage 1: length clamp, pixels = len / 3, relative universe
  always_comb begin
    len_c    = (in_packet_length > dmxpa_pkg::PACKET_LIMIT) ? dmxpa_pkg::PACKET_LIMIT
                                                              : in_packet_length;
    len_prod = 20'(len_c) * 20'(dmxpa_pkg::RECIP3);
    diff     = {1'b0, in_universe} - {1'b0, cfg.start_universe};
    uni_ok   = !diff[15];
    tracked  = dmxpa_pkg::tracked_count(cfg.universe_count);

    s1_next         = '0;
    s1_next.kind    = in_kind;
    s1_next.uni_ok  = uni_ok;
    s1_next.mark    = uni_ok && (diff[14:0] < {9'd0, tracked});
    s1_next.rel_bit = diff[4:0];
    s1_next.pixels  = len_prod[dmxpa_pkg::RECIP3_SHIFT +: 8];
    // offset field carries the relative universe until stage 2
    s1_next.offset  = uni_ok ? {8'd0, diff[14:0]} : 23'd0;
    s1_next.red     = in_red;
    s1_next.green   = in_green;
    s1_next.blue    = in_blue;
  end

  // Stage 2: universe offset = relative universe * pixels of this packet
  always_comb begin
    s2_next        = s1;
    s2_next.offset = 23'(s1.offset[14:0]) * 23'(s1.pixels);
  end

  // Stage registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (adv1) s1_valid <= in_valid;
      if (adv2) s2_valid <= s1_valid;
    end
    if (adv1) s1 <= s1_next;
    if (adv2) s2 <= s2_next;
  end

  assign cmd_valid = s2_valid;
  assign cmd       = s2;

endmodule

[rtl/dmxpa_queue.sv]
// Short FIFO of classified items between front and back.
`timescale 1ns / 1ps

module dmxpa_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_valid,
  output logic            wr_ready,
  input  dmxpa_pkg::cmd_t wr_cmd,
  output logic            rd_valid,
  input  logic            rd_ready,
  output dmxpa_pkg::cmd_t rd_cmd
);

  localparam int unsigned AW = dmxpa_pkg::QUEUE_AW;

  dmxpa_pkg::cmd_t mem [dmxpa_pkg::QUEUE_DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [AW:0]     count;
  logic            push;
  logic            pop;

  assign wr_ready = (count != (AW+1)'(dmxpa_pkg::QUEUE_DEPTH));
  assign rd_valid = (count != '0);
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_cmd   = mem[rd_ptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wr_cmd;
  end

endmodule

[rtl/dmxpa_back.sv]
// Back: packet state, pixel address and write decision, frame show and activity timer.
`timescale 1ns / 1ps

module dmxpa_back (
  input  logic            clk,
  input  logic            rst,
  input  dmxpa_pkg::cfg_t cfg,
  input  logic            cmd_valid,
  output logic            cmd_ready,
  input  dmxpa_pkg::cmd_t cmd,
  output logic            res_valid,
  input  logic            res_ready,
  output dmxpa_pkg::res_t res
);

  logic [31:0] received_map,     received_map_next;
  logic [22:0] universe_offset,  universe_offset_next;
  logic [7:0]  pixels_in_packet, pixels_in_packet_next;
  logic [7:0]  pixel_counter,    pixel_counter_next;
  logic        universe_valid,   universe_valid_next;
  logic [15:0] frames_shown,     frames_shown_next;
  logic        activity_level,   activity_level_next;
  logic [15:0] idle_time,        idle_time_next;

  dmxpa_pkg::res_t res_next;
  logic            take;
  logic [23:0]     addr_sum;
  logic [31:0]     need;
  logic [5:0]      tracked;
  logic [15:0]     idle_inc;

  assign cmd_ready = !res_valid || res_ready;
  assign take      = cmd_valid && cmd_ready;

  // Mask of universes that must be present
  always_comb begin
    tracked = dmxpa_pkg::tracked_count(cfg.universe_count);
    for (int i = 0; i < 32; i++) begin
      need[i] = (6'(i) < tracked);
    end
  end

  // Next state and result for one item
  always_comb begin
    received_map_next     = received_map;
    universe_offset_next  = universe_offset;
    pixels_in_packet_next = pixels_in_packet;
    pixel_counter_next    = pixel_counter;
    universe_valid_next   = universe_valid;
    frames_shown_next     = frames_shown;
    activity_level_next   = activity_level;
    idle_time_next        = idle_time;
    res_next              = '0;
    addr_sum = {1'b0, universe_offset} + {16'd0, pixel_counter};
    idle_inc = (idle_time == 16'hFFFF) ? idle_time : idle_time + 16'd1;

    case (cmd.kind)
      dmxpa_pkg::KIND_HEADER: begin
        pixels_in_packet_next = cmd.pixels;
        pixel_counter_next    = 8'd0;
        universe_valid_next   = cmd.uni_ok;
        universe_offset_next  = cmd.offset;
        if (cmd.mark) received_map_next = received_map | (32'd1 << cmd.rel_bit);
      end
      dmxpa_pkg::KIND_PIXEL: begin
        // first pixel of a packet judges activity
        if (pixel_counter == 8'd0 && cmd.red != 8'd0) begin
          activity_level_next = 1'b1;
          idle_time_next      = 16'd0;
        end
        if (universe_valid && pixel_counter < pixels_in_packet &&
            addr_sum < {10'd0, cfg.led_count} &&
            addr_sum < 24'(dmxpa_pkg::MAX_LEDS)) begin
          res_next.pixel_write   = 1'b1;
          res_next.pixel_address = addr_sum[12:0];
          res_next.out_red       = cmd.red;
          res_next.out_green     = cmd.green;
          res_next.out_blue      = cmd.blue;
        end
        if (pixel_counter != 8'hFF) pixel_counter_next = pixel_counter + 8'd1;
      end
      dmxpa_pkg::KIND_END: begin
        if ((received_map & need) == need) begin
          res_next.frame_show = 1'b1;
          frames_shown_next   = frames_shown + 16'd1;
          received_map_next   = 32'd0;
        end
        universe_valid_next = 1'b0;
      end
      dmxpa_pkg::KIND_TICK: begin
        idle_time_next = idle_inc;
        if (idle_inc > cfg.idle_timeout_ms) activity_level_next = 1'b0;
      end
      default: begin
      end
    endcase

    res_next.frame_number = frames_shown_next;
    res_next.activity_led = activity_level_next;
  end

  // State and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      received_map     <= 32'd0;
      universe_offset  <= 23'd0;
      pixels_in_packet <= 8'd0;
      pixel_counter    <= 8'd0;
      universe_valid   <= 1'b0;
      frames_shown     <= 16'd0;
      activity_level   <= 1'b0;
      idle_time        <= 16'd0;
      res_valid        <= 1'b0;
    end else begin
      if (take) begin
        received_map     <= received_map_next;
        universe_offset  <= universe_offset_next;
        pixels_in_packet <= pixels_in_packet_next;
        pixel_counter    <= pixel_counter_next;
        universe_valid   <= universe_valid_next;
        frames_shown     <= frames_shown_next;
        activity_level   <= activity_level_next;
        idle_time        <= idle_time_next;
      end
      if (cmd_ready) res_valid <= cmd_valid;
    end
    if (take) res <= res_next;
  end

endmodule

[rtl/dmx_universe_pixel_assembler.sv]
// Top level: lighting universe packets to frame-buffer pixel writes.
//
// Input stream (s_*): one item per packet header, RGB pixel, end of packet or
// millisecond tick, kind in s_tuser. Output stream (m_*): exactly one result
// item per input item, in order: a pixel write (m_tuser high) or a status item,
// each carrying frame_show, frame_number and activity_led.
// Configuration (cfg_*): register writes, taken every cycle; write only while
// no items are in flight. Unknown indexes are ignored.
// A result passes the second front stage, a queue entry, then the back's output
// register before it is valid.
// Throughput: one item per cycle while the output is not stalled; the back
// updates all packet state once per item and the front is fully pipelined.
// Reset clears all packet state, the frame count, the activity timer and sets
// the registers to their defaults; no items are held.
// When the receiver stalls, the result register holds, the back stops, and the
// four-entry queue plus the front stages absorb items before s_tready drops.
`timescale 1ns / 1ps

module dmx_universe_pixel_assembler (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // universe[14:0], packet_length[24:15], red[32:25],
                                 // green[40:33], blue[48:41], zero[55:49]
  input  logic [1:0]  s_tuser,   // kind[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // pixel_address[12:0], out_red[20:13], out_green[28:21],
                                 // out_blue[36:29], frame_show[37], frame_number[53:38],
                                 // activity_led[54], zero[55]
  output logic        m_tuser,   // pixel_write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  dmxpa_pkg::cfg_t cfg;
  logic            f_valid;
  logic            f_ready;
  dmxpa_pkg::cmd_t f_cmd;
  logic            q_valid;
  logic            q_ready;
  dmxpa_pkg::cmd_t q_cmd;
  dmxpa_pkg::res_t res;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_universe  <= dmxpa_pkg::START_UNIVERSE_RST;
      cfg.led_count       <= dmxpa_pkg::LED_COUNT_RST;
      cfg.universe_count  <= dmxpa_pkg::UNIVERSE_COUNT_RST;
      cfg.idle_timeout_ms <= dmxpa_pkg::IDLE_TIMEOUT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        dmxpa_pkg::REG_START_UNIVERSE: cfg.start_universe  <= cfg_data[14:0];
        dmxpa_pkg::REG_LED_COUNT:      cfg.led_count       <= cfg_data[13:0];
        dmxpa_pkg::REG_UNIVERSE_COUNT: cfg.universe_count  <= cfg_data[5:0];
        dmxpa_pkg::REG_IDLE_TIMEOUT:   cfg.idle_timeout_ms <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  dmxpa_front u_front (
    .clk              (clk),
    .rst              (rst),
    .cfg              (cfg),
    .in_valid         (s_tvalid),
    .in_ready         (s_tready),
    .in_kind          (s_tuser),
    .in_universe      (s_tdata[14:0]),
    .in_packet_length (s_tdata[24:15]),
    .in_red           (s_tdata[32:25]),
    .in_green         (s_tdata[40:33]),
    .in_blue          (s_tdata[48:41]),
    .cmd_valid        (f_valid),
    .cmd_ready        (f_ready),
    .cmd              (f_cmd)
  );

  dmxpa_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_cmd   (f_cmd),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_cmd   (q_cmd)
  );

  dmxpa_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_valid (q_valid),
    .cmd_ready (q_ready),
    .cmd       (q_cmd),
    .res_valid (m_tvalid),
    .res_ready (m_tready),
    .res       (res)
  );

  // Output packing
  assign m_tuser = res.pixel_write;
  assign m_tdata = {1'b0, res.activity_led, res.frame_number, res.frame_show,
                    res.out_blue, res.out_green, res.out_red, res.pixel_address};

endmodule

[rtl/dmxpa_checker.sv]
// Port-level checks for the pixel assembler, bound to the top level.
`timescale 1ns / 1ps

module dmxpa_port_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [55:0] m_tdata,
  input logic        m_tuser
);

  // No result item right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // Non-write items carry zero address and color
  a_zero_payload: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[36:0] == 37'd0)
    else $error("address or color nonzero without write");

  // A pixel write never shows a frame
  a_write_no_show: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> !m_tdata[37])
    else $error("write and frame show together");

endmodule

bind dmx_universe_pixel_assembler dmxpa_port_checker u_checker (.*);

[test/dmxpa_checker.sv]
// Checker for the pixel assembler: tracks accepted items, predicts results, compares outputs.
`timescale 1ns / 1ps

module dmxpa_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [55:0] s_tdata,   // universe[14:0], packet_length[24:15], red[32:25],
                                 // green[40:33], blue[48:41], zero[55:49]
  input  logic [1:0]  s_tuser,   // kind[1:0]
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [55:0] m_tdata,   // pixel_address[12:0], out_red[20:13], out_green[28:21],
                                 // out_blue[36:29], frame_show[37], frame_number[53:38],
                                 // activity_led[54], zero[55]
  input  logic        m_tuser,   // pixel_write
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          fail_count,
  output int          pending
);

  // Register copy
  logic [14:0] first_universe;
  logic [13:0] led_limit;
  logic [5:0]  needed_universes;
  logic [15:0] idle_limit;

  // Frame assembly state
  logic [31:0] seen_map;
  logic [22:0] base_index;
  logic [7:0]  packet_pixels;
  logic [7:0]  pixel_index;
  logic        in_frame;
  logic [15:0] shown_count;
  logic        lit;
  logic [15:0] quiet_ms;

  dmxpa_pkg::res_t results_due[$];
  dmxpa_pkg::res_t want;
  dmxpa_pkg::res_t got;
  int              mismatches;
  int              results_seen;

  assign fail_count = mismatches;

  // Result of one item; updates the frame state as the block would
  function automatic dmxpa_pkg::res_t assemble_result(input logic [1:0] kind,
                                                      input logic [14:0] uni,
                                                      input logic [9:0] len,
                                                      input logic [7:0] r,
                                                      input logic [7:0] g,
                                                      input logic [7:0] b);
    dmxpa_pkg::res_t res;
    int unsigned     plen;
    int unsigned     rel;
    int unsigned     track;
    int unsigned     addr;
    logic [31:0]     need;
    res = '0;
    track = (needed_universes > 6'd32) ? 32 : needed_universes;
    case (kind)
      dmxpa_pkg::KIND_HEADER: begin
        plen = (len > 10'd512) ? 512 : len;
        packet_pixels = 8'(plen / 3);
        pixel_index = '0;
        in_frame = (uni >= first_universe);
        rel = in_frame ? uni - first_universe : 0;
        base_index = 23'(rel * packet_pixels);
        if (in_frame && rel < track) seen_map[rel] = 1'b1;
      end
      dmxpa_pkg::KIND_PIXEL: begin
        // activity follows the first data byte of a packet
        if (pixel_index == 8'd0 && r != 8'd0) begin
          lit = 1'b1;
          quiet_ms = '0;
        end
        if (in_frame && pixel_index < packet_pixels) begin
          addr = base_index + pixel_index;
          if (addr < led_limit && addr < dmxpa_pkg::MAX_LEDS) begin
            res.pixel_write = 1'b1;
            res.pixel_address = 13'(addr);
            res.out_red = r;
            res.out_green = g;
            res.out_blue = b;
          end
        end
        if (pixel_index != 8'hFF) pixel_index++;
      end
      dmxpa_pkg::KIND_END: begin
        need = (track >= 32) ? '1 : (32'd1 << track) - 32'd1;
        if ((seen_map & need) == need) begin
          res.frame_show = 1'b1;
          shown_count++;
          seen_map = '0;
        end
        in_frame = 1'b0;
      end
      default: begin
        if (quiet_ms != 16'hFFFF) quiet_ms++;
        if (quiet_ms > idle_limit) lit = 1'b0;
      end
    endcase
    res.frame_number = shown_count;
    res.activity_led = lit;
    return res;
  endfunction

  task automatic check_field(input string field, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      if (mismatches < 10)
        $display("result %0d: %s expected %0d, got %0d", results_seen, field, exp_v, act_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      first_universe = dmxpa_pkg::START_UNIVERSE_RST;
      led_limit = dmxpa_pkg::LED_COUNT_RST;
      needed_universes = dmxpa_pkg::UNIVERSE_COUNT_RST;
      idle_limit = dmxpa_pkg::IDLE_TIMEOUT_RST;
      seen_map = '0;
      base_index = '0;
      packet_pixels = '0;
      pixel_index = '0;
      in_frame = 1'b0;
      shown_count = '0;
      lit = 1'b0;
      quiet_ms = '0;
      results_due.delete();
      results_seen = 0;
      mismatches = 0;
    end else begin
      // outgoing result against the oldest expectation
      if (m_tvalid && m_tready) begin
        got.pixel_write = m_tuser;
        got.pixel_address = m_tdata[12:0];
        got.out_red = m_tdata[20:13];
        got.out_green = m_tdata[28:21];
        got.out_blue = m_tdata[36:29];
        got.frame_show = m_tdata[37];
        got.frame_number = m_tdata[53:38];
        got.activity_led = m_tdata[54];
        if (results_due.size() == 0) begin
          if (mismatches < 10) $display("result %0d arrived with none expected", results_seen);
          mismatches++;
        end else begin
          want = results_due.pop_front();
          check_field("pixel_write", want.pixel_write, got.pixel_write);
          check_field("pixel_address", want.pixel_address, got.pixel_address);
          check_field("out_red", want.out_red, got.out_red);
          check_field("out_green", want.out_green, got.out_green);
          check_field("out_blue", want.out_blue, got.out_blue);
          check_field("frame_show", want.frame_show, got.frame_show);
          check_field("frame_number", want.frame_number, got.frame_number);
          check_field("activity_led", want.activity_led, got.activity_led);
        end
        results_seen++;
      end
      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          dmxpa_pkg::REG_START_UNIVERSE: first_universe = cfg_data[14:0];
          dmxpa_pkg::REG_LED_COUNT:      led_limit = cfg_data[13:0];
          dmxpa_pkg::REG_UNIVERSE_COUNT: needed_universes = cfg_data[5:0];
          dmxpa_pkg::REG_IDLE_TIMEOUT:   idle_limit = cfg_data;
          default: ;
        endcase
      end
      // incoming item
      if (s_tvalid && s_tready)
        results_due.push_back(assemble_result(s_tuser, s_tdata[14:0], s_tdata[24:15],
                                              s_tdata[32:25], s_tdata[40:33], s_tdata[48:41]));
    end
    pending <= results_due.size();
  end

endmodule

[test/tb.sv]
// Testbench top for the pixel assembler: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [55:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [55:0] m_tdata;
  logic        m_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [3:0]  cfg_index;
  logic [15:0] cfg_data;
  int          fail_count;
  int          pending;

  int          send_gap_pct;
  int          take_gap_pct;
  int          items_sent;
  int          walk;
  logic [14:0] cur_start;
  logic [5:0]  cur_count;
  logic [15:0] cur_timeout;

  dmx_universe_pixel_assembler u_top (.*);
  dmxpa_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Run limit
  initial begin
    #(5_000_000);
    $display("tb: failure");
    $finish;
  end

  // Receiver back-pressure
  always @(posedge clk) m_tready <= ($urandom_range(99) >= take_gap_pct);

  // One input item, with a random gap ahead of it
  task automatic send_item(input logic [1:0] kind, input logic [14:0] uni,
                           input logic [9:0] len, input logic [7:0] r,
                           input logic [7:0] g, input logic [7:0] b);
    logic rdy;
    while ($urandom_range(99) < send_gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {7'd0, b, g, r, len, uni};
    s_tuser <= kind;
    do begin
      @(negedge clk);
      rdy = s_tready;
      @(posedge clk);
    end while (!rdy);
    items_sent++;
  endtask

  // Unused fields carry random junk
  task automatic send_header(input logic [14:0] uni, input logic [9:0] len);
    send_item(dmxpa_pkg::KIND_HEADER, uni, len, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    send_item(dmxpa_pkg::KIND_PIXEL, 15'($urandom), 10'($urandom), r, g, b);
  endtask

  task automatic send_ctl(input logic [1:0] kind);
    send_item(kind, 15'($urandom), 10'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // Wait until every expected result is out, then let the pipeline settle
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [3:0] idx, input logic [15:0] val);
    logic rdy;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do begin
      @(negedge clk);
      rdy = cfg_ready;
      @(posedge clk);
    end while (!rdy);
  endtask

  task automatic configure(input logic [14:0] su, input logic [13:0] lc,
                           input logic [5:0] uc, input logic [15:0] to);
    wait_idle();
    write_reg(dmxpa_pkg::REG_START_UNIVERSE, {1'b0, su});
    write_reg(dmxpa_pkg::REG_LED_COUNT, {2'b0, lc});
    write_reg(dmxpa_pkg::REG_UNIVERSE_COUNT, {10'b0, uc});
    write_reg(dmxpa_pkg::REG_IDLE_TIMEOUT, to);
    cfg_valid <= 1'b0;
    cur_start = su;
    cur_count = uc;
    cur_timeout = to;
    walk = 0;
  endtask

  // A packet: header, pixels with ticks mixed in, end; sometimes malformed
  task automatic send_packet();
    int          choose;
    int          rel;
    int          npix;
    int          plen;
    logic [14:0] uni;
    logic [9:0]  len;
    choose = $urandom_range(99);
    if (choose < 70) begin
      uni = 15'(cur_start + walk);
      walk = (walk + 1) % (cur_count + 2);
    end else if (choose < 85) begin
      rel = $urandom_range(0, cur_count + 3);
      uni = 15'(cur_start + rel);
    end else if (choose < 92) begin
      uni = cur_start - 15'($urandom_range(1, 4));
    end else begin
      uni = 15'($urandom);
    end
    if ($urandom_range(19) == 0) len = 10'($urandom_range(480, 1023));
    else len = 10'($urandom_range(0, 30));
    plen = (len > 10'd512) ? 512 : len;
    npix = plen / 3;
    choose = $urandom_range(9);
    if (choose == 0) npix += $urandom_range(1, 3);
    else if (choose == 1 && npix > 0) npix--;
    send_header(uni, len);
    for (int i = 0; i < npix; i++) begin
      if ($urandom_range(9) == 0) send_ctl(dmxpa_pkg::KIND_TICK);
      if (i == 0 && $urandom_range(3) == 0) send_pixel(8'd0, 8'($urandom), 8'($urandom));
      else send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
    end
    if ($urandom_range(14) != 0) send_ctl(dmxpa_pkg::KIND_END);
  endtask

  initial begin
    int phase_end;
    int noise;
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tuser <= dmxpa_pkg::KIND_HEADER;
    m_tready <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= dmxpa_pkg::REG_START_UNIVERSE;
    cfg_data <= '0;
    items_sent = 0;
    walk = 0;
    send_gap_pct = 33;
    take_gap_pct = 52;
    cur_start = dmxpa_pkg::START_UNIVERSE_RST;
    cur_count = dmxpa_pkg::UNIVERSE_COUNT_RST;
    cur_timeout = dmxpa_pkg::IDLE_TIMEOUT_RST;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: stray items, field extremes, surplus, short and long packets
    send_pixel(8'hFF, 8'h00, 8'hFF);
    send_ctl(dmxpa_pkg::KIND_END);
    send_ctl(dmxpa_pkg::KIND_TICK);
    send_header(15'd0, 10'd9);
    send_pixel(8'h00, 8'hFF, 8'h00);
    send_pixel(8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'h01, 8'h02, 8'h03);
    send_pixel(8'h04, 8'h05, 8'h06);
    send_ctl(dmxpa_pkg::KIND_END);
    send_header(15'h7FFF, 10'h3FF);
    send_pixel(8'hAA, 8'h55, 8'hAA);
    send_ctl(dmxpa_pkg::KIND_END);
    send_header(15'd2, 10'd2);
    send_pixel(8'h55, 8'hAA, 8'h55);
    send_header(15'd1, 10'd0);
    send_ctl(dmxpa_pkg::KIND_END);
    send_pixel(8'h07, 8'h07, 8'h07);
    send_header(15'd22, 10'd510);
    send_pixel(8'h80, 8'h01, 8'h7F);
    send_pixel(8'hFE, 8'h01, 8'h80);
    send_ctl(dmxpa_pkg::KIND_END);
    send_ctl(dmxpa_pkg::KIND_TICK);

    // Random phases, each under its own register setting
    for (int phase = 0; phase < 9; phase++) begin
      if (phase == 3) begin
        send_gap_pct = 52;
        take_gap_pct = 33;
      end else if (phase == 6) begin
        send_gap_pct = 0;
        take_gap_pct = 0;
      end
      case (phase)
        0: configure(15'd0, 14'd8192, 6'd4, 16'd0);
        1: configure(15'h7FFF, 14'd1, 6'd0, 16'hFFFF);
        2: configure(15'd5, 14'h3FFF, 6'd32, 16'd10);
        3: configure(15'd0, 14'd3888, 6'h3F, 16'd5);
        default: configure(($urandom_range(4) == 0) ? 15'($urandom) : 15'($urandom_range(40)),
                           ($urandom_range(1) == 0) ? 14'($urandom_range(1, 64))
                                                    : 14'($urandom_range(1, 8192)),
                           6'($urandom_range(0, 32)), 16'($urandom_range(0, 30)));
      endcase
      phase_end = items_sent + 190;
      while (items_sent < phase_end) begin
        noise = $urandom_range(99);
        if (noise < 10) send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
        else if (noise < 15) send_ctl(dmxpa_pkg::KIND_END);
        else if (noise < 30)
          repeat ($urandom_range(1, (cur_timeout < 40) ? cur_timeout + 2 : 4))
            send_ctl(dmxpa_pkg::KIND_TICK);
        send_packet();
      end
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/dmxpa_pkg.sv
rtl/dmxpa_front.sv
rtl/dmxpa_queue.sv
rtl/dmxpa_back.sv
rtl/dmx_universe_pixel_assembler.sv
rtl/dmxpa_checker.sv
test/dmxpa_checker.sv
test/tb.sv
